### rtl/gfr_pkg.sv
// gfr_pkg: request codes, word type and gf(256) multiply for the row engine
// no dependencies
`default_nettype none
package gfr_pkg;

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_SWAP  = 3'd2;
  localparam logic [2:0] REQ_ADD   = 3'd3;
  localparam logic [2:0] REQ_SCALE = 3'd4;
  localparam logic [2:0] REQ_AXPY  = 3'd5;
  localparam logic [2:0] REQ_MASK  = 3'd6;

  localparam int LANES = 4;
  localparam logic [8:0] GF_POLY = 9'h11D;

  typedef logic [8*LANES-1:0] word_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [8:0] x;
    acc = 8'h00;
    x = {1'b0, a};
    for (int n = 0; n < 8; n++) begin
      if (b[n]) begin
        acc = acc ^ x[7:0];
      end
      x = x << 1;
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

### rtl/gfr_ram.sv
// gfr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module gfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/gf256_row_operation_engine_unit.sv
// gf256_row_operation_engine_unit: top level of the gf(256) row engine
// depends on gfr_pkg and gfr_ram
`default_nettype none
// Both matrices sit in word-wide rams of four bytes per word. Add, scale, axpy
// and mask axpy stream through one word per cycle (read one word, write back the
// previous one) over up to ceil(count/4) words, with count =
// min(active_columns, COLS); mask axpy covers at most 8 words. A swap
// needs two reads and two writes per word on the single target write port.
// Byte write and byte read go through the prep, setup and byte states. When
// ROWS is below 64, row numbers are first reduced by repeated subtraction. One
// request is in flight at a time; the result register lets the next request
// enter while a result waits.
module gf256_row_operation_engine_unit #(
  parameter int ROWS = 64,
  parameter int COLS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [2:0] req_type,
  input  wire logic       store_select,
  input  wire logic [5:0] target_row,
  input  wire logic [5:0] other_row,
  input  wire logic [7:0] column,
  input  wire logic [7:0] write_byte,
  input  wire logic [7:0] factor,
  input  wire logic [31:0] mask_word,
  input  wire logic [2:0] word_index,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] read_byte,
  output      logic [2:0] done_type
);

  localparam int WPR   = (COLS + gfr_pkg::LANES - 1) / gfr_pkg::LANES;
  localparam int DEPTH = ROWS * WPR;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_RUN   = 4'd3;
  localparam logic [3:0] ST_SW0   = 4'd4;
  localparam logic [3:0] ST_SW1   = 4'd5;
  localparam logic [3:0] ST_SW2   = 4'd6;
  localparam logic [3:0] ST_SWF   = 4'd7;
  localparam logic [3:0] ST_BYTE  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0]  state;
  logic [8:0]  active;
  logic [2:0]  typ;
  logic        sel;
  logic [5:0]  ra, rb;
  logic [7:0]  col, wbyte, f;
  logic [31:0] mask;
  logic [2:0]  widx;
  logic [AW-1:0] base_a, base_b;
  logic [7:0]  w, pw, wend;
  logic        pend;
  gfr_pkg::word_t held_a, held_b;
  logic [7:0]  rbyte;

  logic           t_we, s_we;
  logic [AW-1:0]  t_waddr, s_waddr, t_raddr, s_raddr;
  gfr_pkg::word_t t_wdata, s_wdata, t_rdata, s_rdata;

  logic [8:0]  cnt;
  logic [7:0]  nwords, ws, ws_end, wstart, wlast;
  logic        ra_big, rb_big, col_ok;
  logic [AW-1:0] byte_addr;
  logic [7:0]  act_w;
  logic [3:0]  act;
  gfr_pkg::word_t alu, mix_a, mix_b, merged;
  logic        skip;

  gfr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_target (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  gfr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_source (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign in_stall = (state != ST_IDLE);
  assign cnt = ({23'd0, active} < 32'(COLS)) ? active : 9'(COLS);
  assign nwords = 8'((10'(cnt) + 10'd3) >> 2);
  assign ws = {2'b00, widx, 3'b000};
  assign ws_end = ((9'(ws) + 9'd8) < 9'(nwords)) ? (ws + 8'd8) : nwords;
  assign wstart = (typ == gfr_pkg::REQ_MASK) ? ws : 8'd0;
  assign wlast = (typ == gfr_pkg::REQ_MASK) ? ws_end : nwords;
  assign ra_big = (32'(ra) >= ROWS);
  assign rb_big = (32'(rb) >= ROWS);
  assign col_ok = (32'(col) < COLS);
  assign byte_addr = base_a + AW'(col[7:2]);

  always_comb begin
    skip = 1'b0;
    case (typ)
      gfr_pkg::REQ_SWAP:  skip = (ra == rb);
      gfr_pkg::REQ_SCALE: skip = (f < 8'd2);
      gfr_pkg::REQ_AXPY:  skip = (f == 8'd0);
      gfr_pkg::REQ_ADD, gfr_pkg::REQ_MASK: skip = 1'b0;
      default:            skip = 1'b1;
    endcase
    if (wstart >= wlast) begin
      skip = 1'b1;
    end
  end

  always_comb begin
    logic [9:0] cw;
    act_w = (state == ST_SW2) ? w : pw;
    for (int l = 0; l < gfr_pkg::LANES; l++) begin
      cw = {act_w, 2'(l)};
      act[l] = (cw < 10'(cnt));
      if (typ == gfr_pkg::REQ_MASK) begin
        act[l] = act[l] & mask[{pw[2:0], 2'(l)}];
      end
    end
    for (int l = 0; l < gfr_pkg::LANES; l++) begin
      case (typ)
        gfr_pkg::REQ_ADD:   alu[8*l +: 8] = t_rdata[8*l +: 8] ^ s_rdata[8*l +: 8];
        gfr_pkg::REQ_SCALE: alu[8*l +: 8] = gfr_pkg::gf_mul(f, t_rdata[8*l +: 8]);
        gfr_pkg::REQ_AXPY:
          alu[8*l +: 8] = t_rdata[8*l +: 8] ^ gfr_pkg::gf_mul(f, s_rdata[8*l +: 8]);
        default:            alu[8*l +: 8] = t_rdata[8*l +: 8] ^ f;
      endcase
      if (!act[l]) begin
        alu[8*l +: 8] = t_rdata[8*l +: 8];
      end
      mix_a[8*l +: 8] = act[l] ? t_rdata[8*l +: 8] : held_a[8*l +: 8];
      mix_b[8*l +: 8] = act[l] ? held_a[8*l +: 8] : held_b[8*l +: 8];
      merged[8*l +: 8] = (col[1:0] == 2'(l)) ? wbyte
                         : (sel ? s_rdata[8*l +: 8] : t_rdata[8*l +: 8]);
    end
  end

  always_comb begin
    t_we = 1'b0;
    t_waddr = base_a + AW'(pw);
    t_wdata = alu;
    t_raddr = base_a + AW'(w);
    s_we = 1'b0;
    s_waddr = byte_addr;
    s_wdata = merged;
    s_raddr = base_b + AW'(w);
    case (state)
      ST_SETUP: begin
        t_raddr = byte_addr;
        s_raddr = byte_addr;
      end
      ST_RUN: t_we = pend;
      ST_SW0: begin
        t_we = pend;
        t_waddr = base_b + AW'(pw);
        t_wdata = mix_b;
      end
      ST_SW1: t_raddr = base_b + AW'(w);
      ST_SW2: begin
        t_we = 1'b1;
        t_waddr = base_a + AW'(w);
        t_wdata = mix_a;
      end
      ST_SWF: begin
        t_we = 1'b1;
        t_waddr = base_b + AW'(pw);
        t_wdata = mix_b;
      end
      ST_BYTE: begin
        t_we = (typ == gfr_pkg::REQ_WRITE) && !sel && col_ok;
        s_we = (typ == gfr_pkg::REQ_WRITE) && sel && col_ok;
        t_waddr = byte_addr;
        t_wdata = merged;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= 9'd256;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        active <= cfg_wdata;
      end
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            typ <= req_type;
            sel <= store_select;
            ra <= target_row;
            rb <= other_row;
            col <= column;
            wbyte <= write_byte;
            f <= factor;
            mask <= mask_word;
            widx <= word_index;
            rbyte <= 8'd0;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (ra_big) begin
            ra <= ra - 6'(ROWS);
          end
          if (rb_big) begin
            rb <= rb - 6'(ROWS);
          end
          if (!ra_big && !rb_big) begin
            base_a <= AW'(ra) * AW'(WPR);
            base_b <= AW'(rb) * AW'(WPR);
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          w <= wstart;
          wend <= wlast;
          pend <= 1'b0;
          if (typ == gfr_pkg::REQ_WRITE || typ == gfr_pkg::REQ_READ) begin
            state <= ST_BYTE;
          end else if (skip) begin
            state <= ST_FIN;
          end else if (typ == gfr_pkg::REQ_SWAP) begin
            state <= ST_SW0;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (w < wend) begin
            pw <= w;
            w <= w + 8'd1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_FIN;
            end
          end
        end
        ST_SW0: state <= ST_SW1;
        ST_SW1: begin
          held_a <= t_rdata;
          state <= ST_SW2;
        end
        ST_SW2: begin
          held_b <= t_rdata;
          pw <= w;
          w <= w + 8'd1;
          pend <= 1'b1;
          state <= ((w + 8'd1) < wend) ? ST_SW0 : ST_SWF;
        end
        ST_SWF: state <= ST_FIN;
        ST_BYTE: begin
          if (typ == gfr_pkg::REQ_READ && col_ok) begin
            rbyte <= sel ? s_rdata[8*col[1:0] +: 8] : t_rdata[8*col[1:0] +: 8];
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_byte <= rbyte;
            done_type <= typ;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_PREP)
    else $error("transfer did not start a request");
  a_no_same_word: assert property (@(posedge clk) disable iff (rst)
    t_we && state == ST_RUN |-> t_waddr != t_raddr)
    else $error("streaming write hits the word being read");
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && !(out_valid && out_stall) |=> state == ST_IDLE && out_valid)
    else $error("finished request did not produce a result");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> in_stall)
    else $error("input taken during a row operation");
`endif

endmodule
`default_nettype wire
